// ===== rtl/core/matrix3_inverse_top_macros.svh =====
// Assertion helpers shared by the checker. clk and arst_n come from the enclosing scope.
`ifndef MATRIX3_INVERSE_TOP_MACROS_SVH
`define MATRIX3_INVERSE_TOP_MACROS_SVH

// same-cycle implication
`define M3INV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define M3INV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/m3inv_pkg.sv =====
`default_nettype none
package m3inv_pkg;
	localparam int WORD_BITS   = 32;
	localparam int FRAC_BITS   = 16;
	localparam int ADJ_BITS    = 2 * WORD_BITS + 1;
	localparam int DET_BITS    = 3 * WORD_BITS + 2;
	localparam int NUM_BITS    = ADJ_BITS + 2 * FRAC_BITS;
	localparam int STEP_BITS   = $clog2(WORD_BITS);
	localparam int QUEUE_DEPTH = 4;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [ADJ_BITS-1:0]  adj_t;
	typedef logic signed [DET_BITS-1:0]  det_t;

	typedef struct packed {
		word_t m00; word_t m01; word_t m02;
		word_t m10; word_t m11; word_t m12;
		word_t m20; word_t m21; word_t m22;
	} mat_t;

	typedef struct packed {
		word_t r00; word_t r01; word_t r02;
		word_t r10; word_t r11; word_t r12;
		word_t r20; word_t r21; word_t r22;
		logic  singular;
		logic  saturated;
	} inv_t;

	// cofactors plus determinant, handed from front to back
	typedef struct packed {
		logic [8:0][ADJ_BITS-1:0] adj;
		logic [DET_BITS-1:0]      det;
	} job_t;

	// adjugate entry k = e[a]*e[b] - e[c]*e[d], row-major
	localparam logic [3:0] ADJ_IDX [9][4] = '{
		'{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
	};

	localparam logic [WORD_BITS-1:0] LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic                 ONE_CLIP = (FRAC_BITS > WORD_BITS - 2);
	localparam logic [WORD_BITS-1:0] ONE_VAL  = ONE_CLIP ? LIM_POS :
		(WORD_BITS'(1) << FRAC_BITS);
endpackage
`default_nettype wire

// ===== rtl/core/m3inv_front.sv =====
`default_nettype none
module m3inv_front #(
	parameter int DEPTH = m3inv_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  m3inv_pkg::mat_t   mat,
	input  logic              mat_valid,
	output logic              mat_stall,
	input  logic              pop,
	output logic              job_valid,
	output m3inv_pkg::job_t   job
);
	import m3inv_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                       accept;
	logic [CW-1:0]              cnt_q;
	logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	word_t                      e_s1 [9];
	logic signed [2*WORD_BITS-1:0] pa_s2 [9];
	logic signed [2*WORD_BITS-1:0] pb_s2 [9];
	word_t                      row_s2 [3];
	word_t                      row_s3 [3];
	adj_t                       adj_s3 [9];
	adj_t                       adj_s4 [9];
	adj_t                       adj_s5 [9];
	adj_t                       adj_s6 [9];
	logic signed [2*WORD_BITS:0] pl_s4 [3];
	logic signed [2*WORD_BITS:0] ph_s4 [3];
	logic signed [DET_BITS-2:0] term_s5 [3];
	det_t                       det_s6;

	// credit covers the pipeline and the queue, so pushes never overflow
	assign mat_stall = (cnt_q == CW'(DEPTH));
	assign accept    = mat_valid & ~mat_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			if (accept && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (!accept && pop)
				cnt_q <= cnt_q - CW'(1);
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_s1[0] <= mat.m00; e_s1[1] <= mat.m01; e_s1[2] <= mat.m02;
			e_s1[3] <= mat.m10; e_s1[4] <= mat.m11; e_s1[5] <= mat.m12;
			e_s1[6] <= mat.m20; e_s1[7] <= mat.m21; e_s1[8] <= mat.m22;
		end
		for (int k = 0; k < 9; k++) begin
			pa_s2[k]  <= e_s1[ADJ_IDX[k][0]] * e_s1[ADJ_IDX[k][1]];
			pb_s2[k]  <= e_s1[ADJ_IDX[k][2]] * e_s1[ADJ_IDX[k][3]];
			adj_s3[k] <= ADJ_BITS'(pa_s2[k]) - ADJ_BITS'(pb_s2[k]);
			adj_s4[k] <= adj_s3[k];
			adj_s5[k] <= adj_s4[k];
			adj_s6[k] <= adj_s5[k];
		end
		for (int j = 0; j < 3; j++) begin
			row_s2[j] <= e_s1[j];
			row_s3[j] <= row_s2[j];
			// cofactor split into unsigned low word and signed high part
			pl_s4[j] <= row_s3[j] * $signed({1'b0, adj_s3[3*j][WORD_BITS-1:0]});
			ph_s4[j] <= row_s3[j] * $signed(adj_s3[3*j][2*WORD_BITS:WORD_BITS]);
			term_s5[j] <= ((DET_BITS-1)'(ph_s4[j]) <<< WORD_BITS) + (DET_BITS-1)'(pl_s4[j]);
		end
		det_s6 <= DET_BITS'(term_s5[0]) + DET_BITS'(term_s5[1]) + DET_BITS'(term_s5[2]);
	end

	assign job_valid = v_s6;
	always_comb begin
		for (int k = 0; k < 9; k++)
			job.adj[k] = adj_s6[k];
		job.det = det_s6;
	end
endmodule
`default_nettype wire

// ===== rtl/core/m3inv_queue.sv =====
`default_nettype none
module m3inv_queue #(
	parameter int DEPTH = m3inv_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  m3inv_pkg::job_t  din,
	input  logic             pop,
	output logic             valid,
	output m3inv_pkg::job_t  dout
);
	import m3inv_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign valid = (count_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (!push && pop)
				count_q <= count_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/m3inv_back.sv =====
`default_nettype none
module m3inv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  m3inv_pkg::job_t  job,
	output logic             pop,
	output logic             inv_valid,
	output m3inv_pkg::inv_t  inv,
	input  logic             inv_stall
);
	import m3inv_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [DET_BITS-1:0]    dmag_q;
	logic                   dneg_q;
	logic                   sing_q;
	logic [ADJ_BITS-1:0]    nmag_q [9];
	logic                   nneg_q [9];
	logic [DET_BITS-1:0]    rem_q  [9];
	logic [WORD_BITS-1:0]   nlo_q  [9];
	logic [WORD_BITS-1:0]   quo_q  [9];
	logic                   ovf_q  [9];
	logic                   inv_valid_q;
	inv_t                   inv_q;

	logic [NUM_BITS-1:0]    num    [9];
	logic [DET_BITS-1:0]    rem0   [9];
	logic [DET_BITS:0]      trial  [9];
	logic [DET_BITS:0]      diff   [9];
	logic                   ge     [9];
	logic [WORD_BITS-1:0]   res    [9];
	logic                   clip   [9];
	logic                   out_free;
	logic                   clip_any;
	inv_t                   inv_d;

	assign pop       = (state_q == S_IDLE) && job_valid;
	assign out_free  = !inv_valid_q || !inv_stall;
	assign inv_valid = inv_valid_q;
	assign inv       = inv_q;

	always_comb begin
		logic                 neg;
		logic [WORD_BITS-1:0] lim;
		logic [WORD_BITS-1:0] mag;
		for (int k = 0; k < 9; k++) begin
			num[k]   = {nmag_q[k], {(2*FRAC_BITS){1'b0}}};
			rem0[k]  = DET_BITS'(num[k][NUM_BITS-1:WORD_BITS]);
			trial[k] = {rem_q[k], nlo_q[k][WORD_BITS-1]};
			diff[k]  = trial[k] - {1'b0, dmag_q};
			ge[k]    = (trial[k] >= {1'b0, dmag_q});
			// overflow means the quotient is at least 2^WORD_BITS
			neg      = (nneg_q[k] ^ dneg_q) && (ovf_q[k] || (quo_q[k] != '0));
			lim      = neg ? LIM_NEG : LIM_POS;
			clip[k]  = ovf_q[k] || (quo_q[k] > lim);
			mag      = clip[k] ? lim : quo_q[k];
			res[k]   = neg ? (WORD_BITS'(0) - mag) : mag;
			if (sing_q) begin
				res[k]  = (k % 4 == 0) ? ONE_VAL : '0;
				clip[k] = 1'b0;
			end
		end
		clip_any = sing_q ? ONE_CLIP : 1'b0;
		for (int k = 0; k < 9; k++)
			clip_any = clip_any | clip[k];
		inv_d.r00 = res[0]; inv_d.r01 = res[1]; inv_d.r02 = res[2];
		inv_d.r10 = res[3]; inv_d.r11 = res[4]; inv_d.r12 = res[5];
		inv_d.r20 = res[6]; inv_d.r21 = res[7]; inv_d.r22 = res[8];
		inv_d.singular  = sing_q;
		inv_d.saturated = clip_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			inv_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					step_q  <= STEP_BITS'(WORD_BITS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q - STEP_BITS'(1);
					if (step_q == '0)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_FIN && out_free)
				inv_valid_q <= 1'b1;
			else if (!inv_stall)
				inv_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dneg_q <= job.det[DET_BITS-1];
			dmag_q <= job.det[DET_BITS-1] ? (DET_BITS'(0) - job.det) : job.det;
			sing_q <= (job.det == '0);
			for (int k = 0; k < 9; k++) begin
				nneg_q[k] <= job.adj[k][ADJ_BITS-1];
				nmag_q[k] <= job.adj[k][ADJ_BITS-1] ? (ADJ_BITS'(0) - job.adj[k]) : job.adj[k];
			end
		end
		for (int k = 0; k < 9; k++) begin
			if (state_q == S_PREP) begin
				rem_q[k] <= rem0[k];
				ovf_q[k] <= (rem0[k] >= dmag_q);
				nlo_q[k] <= num[k][WORD_BITS-1:0];
			end else if (state_q == S_DIV) begin
				rem_q[k] <= ge[k] ? diff[k][DET_BITS-1:0] : trial[k][DET_BITS-1:0];
				quo_q[k] <= {quo_q[k][WORD_BITS-2:0], ge[k]};
				nlo_q[k] <= nlo_q[k] << 1;
			end
		end
		if (state_q == S_FIN && out_free)
			inv_q <= inv_d;
	end
endmodule
`default_nettype wire

// ===== rtl/core/matrix3_inverse_top.sv =====
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// mat channel: one matrix per item (mat_valid / mat_stall), row-major elements.
// inv channel: one inverse per item (inv_valid / inv_stall) plus singular and
// saturated flags. A zero determinant gives the identity with singular set.
// Front: six-stage pipeline forms the nine cofactors and the determinant and
// can take one item per cycle unless mat_stall is high. A queue of DEPTH jobs
// sits between front and back; mat_stall rises once DEPTH items are held between
// the input and the divider. Back: nine restoring divider lanes, one quotient
// bit per cycle, shared control. The divider sets the pace: the back pops a new
// job only after its last result has gone to the output register.
// The result sits in an output register; the divider keeps working on the next
// item while inv_stall holds it, and waits only when its next result is ready.
// Reset (arst_n low) empties the pipeline, queue and output register; no item
// is lost or duplicated across inv_stall.
`default_nettype none
module matrix3_inverse_top #(
	parameter int DEPTH = m3inv_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  m3inv_pkg::mat_t  mat,
	input  logic             mat_valid,
	output logic             mat_stall,
	output m3inv_pkg::inv_t  inv,
	output logic             inv_valid,
	input  logic             inv_stall
);
	import m3inv_pkg::*;

	logic push;
	job_t job_in;
	logic job_valid;
	job_t job_out;
	logic pop;

	m3inv_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat       (mat),
		.mat_valid (mat_valid),
		.mat_stall (mat_stall),
		.pop       (pop),
		.job_valid (push),
		.job       (job_in)
	);

	m3inv_queue #(.DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.valid  (job_valid),
		.dout   (job_out)
	);

	m3inv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.pop       (pop),
		.inv_valid (inv_valid),
		.inv       (inv),
		.inv_stall (inv_stall)
	);
endmodule
`default_nettype wire

// ===== rtl/core/m3inv_checker.sv =====
`default_nettype none
`include "matrix3_inverse_top_macros.svh"
module m3inv_checker (
	input logic             clk,
	input logic             arst_n,
	input m3inv_pkg::mat_t  mat,
	input logic             mat_valid,
	input logic             mat_stall,
	input m3inv_pkg::inv_t  inv,
	input logic             inv_valid,
	input logic             inv_stall
);
	import m3inv_pkg::*;

	`M3INV_ASSERT_NEXT(a_mat_holds, mat_valid && mat_stall,
		mat_valid && $stable(mat), "mat item changed while stalled")
	`M3INV_ASSERT_NEXT(a_valid_holds, inv_valid && inv_stall, inv_valid,
		"inv_valid dropped while stalled")
	`M3INV_ASSERT_NEXT(a_item_holds, inv_valid && inv_stall, $stable(inv),
		"inv item changed while stalled")
	`M3INV_ASSERT_NOW(a_sing_offdiag, inv_valid && inv.singular,
		inv.r01 == '0 && inv.r02 == '0 && inv.r10 == '0 &&
		inv.r12 == '0 && inv.r20 == '0 && inv.r21 == '0,
		"singular result has nonzero off-diagonal")
	`M3INV_ASSERT_NOW(a_sing_diag, inv_valid && inv.singular,
		inv.r00 == ONE_VAL && inv.r11 == ONE_VAL && inv.r22 == ONE_VAL &&
		inv.saturated == ONE_CLIP,
		"singular result is not the identity")
endmodule

bind matrix3_inverse_top m3inv_checker u_chk (.*);
`default_nettype wire
